/* hdl/tlts_pkg.sv */
// Shared definitions for the token scanner: widths, token kind codes,
// character codes, reserved word tables and controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package tlts_pkg;

  localparam int CHAR_W = 8;
  localparam int KIND_W = 5;
  localparam int POS_W  = 5;
  localparam int LEN_W  = 6;
  localparam int NWORDS = 8;

  // Token kinds
  localparam logic [KIND_W-1:0] K_ENDFILE = 5'd0;
  localparam logic [KIND_W-1:0] K_ERROR   = 5'd1;
  localparam logic [KIND_W-1:0] K_IF      = 5'd2;
  localparam logic [KIND_W-1:0] K_ID      = 5'd10;
  localparam logic [KIND_W-1:0] K_NUM     = 5'd11;
  localparam logic [KIND_W-1:0] K_ASSIGN  = 5'd12;
  localparam logic [KIND_W-1:0] K_EQ      = 5'd13;
  localparam logic [KIND_W-1:0] K_LT      = 5'd14;
  localparam logic [KIND_W-1:0] K_PLUS    = 5'd15;
  localparam logic [KIND_W-1:0] K_MINUS   = 5'd16;
  localparam logic [KIND_W-1:0] K_TIMES   = 5'd17;
  localparam logic [KIND_W-1:0] K_OVER    = 5'd18;
  localparam logic [KIND_W-1:0] K_LPAREN  = 5'd19;
  localparam logic [KIND_W-1:0] K_RPAREN  = 5'd20;
  localparam logic [KIND_W-1:0] K_SEMI    = 5'd21;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_EQ     = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_LT     = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;

  // Reserved words, stored reversed so that character 0 sits in the low byte
  localparam logic [47:0] RW_TEXT [NWORDS] = '{
    48'("fi"), 48'("neht"), 48'("esle"), 48'("dne"),
    48'("taeper"), 48'("litnu"), 48'("daer"), 48'("etirw")
  };
  localparam logic [2:0] RW_LEN [NWORDS] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd6, 3'd5, 3'd4, 3'd5
  };

  // Character p of reserved word w
  function automatic logic [CHAR_W-1:0] rw_byte(input logic [2:0] w, input logic [2:0] p);
    logic [47:0] t;
    t = RW_TEXT[w];
    case (p)
      3'd0:    return t[7:0];
      3'd1:    return t[15:8];
      3'd2:    return t[23:16];
      3'd3:    return t[31:24];
      3'd4:    return t[39:32];
      3'd5:    return t[47:40];
      default: return '0;
    endcase
  endfunction

  // Controller to datapath
  typedef struct packed {
    logic apply;          // run one scanner pass on the current character
    logic sel_latch;      // take the character from the latch, not the port
    logic latch_in;       // capture the incoming item
    logic idx_clear;      // restart lexeme readout
    logic idx_inc;        // advance lexeme readout
    logic out_load;       // load the output register
    logic again_pending;  // a second pass follows this token
  } tlts_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic emit;       // the pass finishes a token
    logic again;      // the character must be processed again from start
    logic out_free;   // output register can take an item
    logic last_char;  // readout index is at the final lexeme character
  } tlts_status_t;

endpackage

/* hdl/tlts_ctrl.sv */
// Sequencing controller for the token scanner: input handshake, lexeme
// readout steps and the second pass. Depends on tlts_pkg.
`timescale 1ns / 1ps

module tlts_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  tlts_pkg::tlts_status_t status,
  output tlts_pkg::tlts_cmd_t    cmd
);
  import tlts_pkg::*;

  typedef enum logic [3:0] {
    C_IDLE  = 4'b0001,
    C_READ  = 4'b0010,
    C_PUT   = 4'b0100,
    C_PASS2 = 4'b1000
  } ctl_state_t;

  ctl_state_t state, state_next;
  logic       again_r, again_r_next;

  // Next state and commands
  always_comb begin
    state_next   = state;
    again_r_next = again_r;
    cmd          = '0;
    cmd.again_pending = again_r;
    s_tready     = 1'b0;
    case (state)
      C_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.apply    = 1'b1;
          cmd.latch_in = 1'b1;
          if (status.emit) begin
            cmd.idx_clear = 1'b1;
            again_r_next  = status.again;
            state_next    = C_READ;
          end
        end
      end
      C_READ: begin
        state_next = C_PUT;
      end
      C_PUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (status.last_char) begin
            state_next = again_r ? C_PASS2 : C_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = C_READ;
          end
        end
      end
      C_PASS2: begin
        cmd.apply     = 1'b1;
        cmd.sel_latch = 1'b1;
        again_r_next  = 1'b0;
        if (status.emit) begin
          cmd.idx_clear = 1'b1;
          state_next    = C_READ;
        end else begin
          state_next = C_IDLE;
        end
      end
      default: begin
        state_next = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= C_IDLE;
      again_r <= 1'b0;
    end else begin
      state   <= state_next;
      again_r <= again_r_next;
    end
  end

endmodule

/* hdl/tlts_datapath.sv */
// Scanner datapath: automaton state, lexeme buffer memory, reserved word
// match flags, readout index and output register. Depends on tlts_pkg.
`timescale 1ns / 1ps

module tlts_datapath #(
  parameter int MAX_LEXEME = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [7:0]             s_tdata,
  input  logic                   s_tuser,
  input  tlts_pkg::tlts_cmd_t    cmd,
  output tlts_pkg::tlts_status_t status,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [23:0]            m_tdata,
  output logic [5:0]             m_tuser,
  output logic                   m_tlast
);
  import tlts_pkg::*;

  localparam int CW = $clog2(MAX_LEXEME + 1);
  localparam int AW = $clog2(MAX_LEXEME);

  typedef enum logic [4:0] {
    SC_START   = 5'b00001,
    SC_ASSIGN  = 5'b00010,
    SC_COMMENT = 5'b00100,
    SC_NUM     = 5'b01000,
    SC_ID      = 5'b10000
  } scan_state_t;

  scan_state_t       scan_state, st_next;
  logic [CW-1:0]     count, count_next, base_count;
  logic [NWORDS-1:0] match, match_next, base_match;
  logic [CHAR_W-1:0] char_l;
  logic              eof_l;
  logic [CHAR_W-1:0] lex_mem [MAX_LEXEME];
  logic [CHAR_W-1:0] rd_data;
  logic [AW-1:0]     idx;
  logic [KIND_W-1:0] kind_l, kind, word_kind;
  logic [CHAR_W-1:0] cur_c;
  logic              cur_eof;
  logic              keep, clear, emit, again, keep_ok;
  logic              is_digit, is_alpha, is_ws, l_starts, start_emits;
  logic              last_char;

  logic [CHAR_W-1:0] out_char;
  logic [POS_W-1:0]  out_pos;
  logic [LEN_W-1:0]  out_len;
  logic [KIND_W-1:0] out_kind;
  logic              out_end, out_run_last;

  // Kind of a one-character token
  function automatic logic [KIND_W-1:0] single_kind(input logic [CHAR_W-1:0] c);
    case (c)
      CH_EQ:     return K_EQ;
      CH_LT:     return K_LT;
      CH_PLUS:   return K_PLUS;
      CH_MINUS:  return K_MINUS;
      CH_STAR:   return K_TIMES;
      CH_SLASH:  return K_OVER;
      CH_LPAREN: return K_LPAREN;
      CH_RPAREN: return K_RPAREN;
      CH_SEMI:   return K_SEMI;
      default:   return K_ERROR;
    endcase
  endfunction

  // Select the character for this pass
  assign cur_c   = cmd.sel_latch ? char_l : s_tdata;
  assign cur_eof = cmd.sel_latch ? eof_l : s_tuser;

  assign is_digit = (cur_c >= 8'h30) && (cur_c <= 8'h39);
  assign is_alpha = ((cur_c >= 8'h41) && (cur_c <= 8'h5A)) ||
                    ((cur_c >= 8'h61) && (cur_c <= 8'h7A));
  assign is_ws    = (cur_c == CH_SPACE) || (cur_c == CH_TAB) || (cur_c == CH_LF);

  // Does the latched character, seen from start, finish a token
  assign l_starts = ((char_l >= 8'h30) && (char_l <= 8'h39)) ||
                    ((char_l >= 8'h41) && (char_l <= 8'h5A)) ||
                    ((char_l >= 8'h61) && (char_l <= 8'h7A)) ||
                    (char_l == CH_COLON) || (char_l == CH_SPACE) ||
                    (char_l == CH_TAB) || (char_l == CH_LF) || (char_l == CH_LBRACE);
  assign start_emits = eof_l || !l_starts;

  // Reserved word lookup on the stored lexeme, first match wins
  always_comb begin
    word_kind = K_ID;
    for (int i = NWORDS - 1; i >= 0; i--) begin
      if (match[i] && (count == CW'(RW_LEN[i]))) begin
        word_kind = KIND_W'(int'(K_IF) + i);
      end
    end
  end

  // Scanner automaton, one pass
  always_comb begin
    st_next = scan_state;
    keep    = 1'b0;
    clear   = 1'b0;
    emit    = 1'b0;
    again   = 1'b0;
    kind    = K_ERROR;
    case (scan_state)
      SC_START: begin
        clear = 1'b1;
        if (cur_eof) begin
          emit = 1'b1;
          kind = K_ENDFILE;
        end else if (is_digit) begin
          keep    = 1'b1;
          st_next = SC_NUM;
        end else if (is_alpha) begin
          keep    = 1'b1;
          st_next = SC_ID;
        end else if (cur_c == CH_COLON) begin
          keep    = 1'b1;
          st_next = SC_ASSIGN;
        end else if (is_ws) begin
          st_next = SC_START;
        end else if (cur_c == CH_LBRACE) begin
          st_next = SC_COMMENT;
        end else begin
          keep = 1'b1;
          emit = 1'b1;
          kind = single_kind(cur_c);
        end
      end
      SC_COMMENT: begin
        if (cur_eof) begin
          clear   = 1'b1;
          emit    = 1'b1;
          kind    = K_ENDFILE;
          st_next = SC_START;
        end else if (cur_c == CH_RBRACE) begin
          st_next = SC_START;
        end
      end
      SC_ASSIGN: begin
        st_next = SC_START;
        emit    = 1'b1;
        if (!cur_eof && (cur_c == CH_EQ)) begin
          keep = 1'b1;
          kind = K_ASSIGN;
        end else begin
          kind  = K_ERROR;
          again = 1'b1;
        end
      end
      SC_NUM: begin
        if (!cur_eof && is_digit) begin
          keep = 1'b1;
        end else begin
          st_next = SC_START;
          emit    = 1'b1;
          again   = 1'b1;
          kind    = K_NUM;
        end
      end
      SC_ID: begin
        if (!cur_eof && is_alpha) begin
          keep = 1'b1;
        end else begin
          st_next = SC_START;
          emit    = 1'b1;
          again   = 1'b1;
          kind    = word_kind;
        end
      end
      default: begin
        st_next = SC_START;
        clear   = 1'b1;
      end
    endcase
  end

  // Lexeme count and reserved word flags after this pass
  assign base_count = clear ? '0 : count;
  assign base_match = clear ? '1 : match;
  assign keep_ok    = keep && (base_count < CW'(MAX_LEXEME));
  assign count_next = base_count + CW'(keep_ok);

  always_comb begin
    match_next = base_match;
    if (keep_ok) begin
      for (int i = 0; i < NWORDS; i++) begin
        match_next[i] = base_match[i] && (base_count < CW'(RW_LEN[i])) &&
                        (cur_c == rw_byte(3'(i), base_count[2:0]));
      end
    end
  end

  // Automaton registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state <= SC_START;
      count      <= '0;
      match      <= '1;
    end else if (cmd.apply) begin
      scan_state <= st_next;
      count      <= count_next;
      match      <= match_next;
    end
  end

  // Input latch and kind of the token being read out
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      char_l <= s_tdata;
      eof_l  <= s_tuser;
    end
    if (cmd.apply && emit) begin
      kind_l <= kind;
    end
  end

  // Lexeme buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.apply && keep_ok) begin
      lex_mem[base_count[AW-1:0]] <= cur_c;
    end
    rd_data <= lex_mem[idx];
  end

  // Readout index
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_clear) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + AW'(1);
    end
  end

  assign last_char = (count == '0) || ((CW'(idx) + CW'(1)) == count);

  // Output item fields
  assign out_kind     = kind_l;
  assign out_char     = (count == '0) ? '0 : rd_data;
  assign out_pos      = POS_W'(idx);
  assign out_len      = LEN_W'(count);
  assign out_end      = last_char;
  assign out_run_last = last_char && !(cmd.again_pending && start_emits);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {5'b0, out_len, out_pos, out_char};
      m_tuser <= {out_end, out_kind};
      m_tlast <= out_run_last;
    end
  end

  assign status.emit      = emit;
  assign status.again     = again;
  assign status.out_free  = !m_tvalid || m_tready;
  assign status.last_char = last_char;

endmodule

/* hdl/tiny_language_token_scanner.sv */
// Top level of the token scanner: joins the sequencing controller and the
// scanner datapath. Depends on tlts_pkg, tlts_ctrl and tlts_datapath.
`timescale 1ns / 1ps

// Scanner for a small teaching language. Each input item carries one source
// character, or an end-of-input flag. Each finished token leaves as a run of
// output items, one per stored lexeme character (ENDFILE: one empty item);
// tlast marks the final item caused by one input item. A character that
// finishes no token leaves no output and the scanner stays ready for the
// next one. The lexeme buffer is a memory with one registered read port, so
// each output item, the empty ENDFILE item too, costs a read step and an
// output load step. A character that ends a number, identifier or bad
// assign is scanned again from start in a second pass, which reads out a
// further token if it also finishes one. Input is not taken while a token is
// read out, and a stalled output extends the readout.
module tiny_language_token_scanner #(
  parameter int MAX_LEXEME = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tuser,   // [0] end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] lexeme_char, [12:8] char_position,
                                 // [18:13] lexeme_length, [23:19] zero
  output logic [5:0]  m_tuser,   // [4:0] token_kind, [5] token_end
  output logic        m_tlast    // run_last
);
  import tlts_pkg::*;

  tlts_cmd_t    cmd;
  tlts_status_t status;

  tlts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tlts_datapath #(
    .MAX_LEXEME (MAX_LEXEME)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
